@@ rtl/pkcs1uv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkcs1uv_pkg
// Shared types and constants for the PKCS#1 v1.5 unpad / verify block.
// ----------------------------------------------------------------------------
package pkcs1uv_pkg;

	// Sizing
	localparam int MAX_DIGEST_BYTES = 64;
	localparam int MAX_BLOCK_BYTES  = 512;
	localparam int DIG_AW           = $clog2(MAX_DIGEST_BYTES);
	localparam int POS_W            = $clog2(MAX_BLOCK_BYTES);
	localparam int CUR_W            = 7;
	localparam int LEN_W            = 7;
	localparam int MIN_SEP_INDEX    = 10;

	// Input kinds
	localparam logic ACT_BLOCK  = 1'b0;
	localparam logic ACT_DIGEST = 1'b1;

	// Configuration register indexes
	localparam logic CFG_MODE       = 1'b0;
	localparam logic CFG_DIGEST_LEN = 1'b1;

	// Mode values
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_SIG = 1'b1;

	// Encoding bytes
	localparam logic [7:0] HDR_LEAD = 8'h00;
	localparam logic [7:0] TYPE_ENC = 8'h02;
	localparam logic [7:0] TYPE_SIG = 8'h01;
	localparam logic [7:0] PAD_SIG  = 8'hFF;
	localparam logic [7:0] SEP_BYTE = 8'h00;

	localparam logic [LEN_W-1:0] DIGEST_LEN_RST = LEN_W'(32);

	typedef enum logic [1:0] {
		PH_HDR0,
		PH_HDR1,
		PH_PAD,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_HEADER,
		ST_NO_SEP,
		ST_SHORT_PAD,
		ST_BAD_PAD,
		ST_LEN_MISMATCH,
		ST_DIGEST_MISMATCH
	} status_t;

	// One result item
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       msg_valid;
		logic       done_res;
		status_t    status;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/pkcs1uv_digest_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkcs1uv_digest_ram
// Expected-digest store: one write port, one registered read port with
// write-to-read forwarding so the read data always matches the array.
// ----------------------------------------------------------------------------
module pkcs1uv_digest_ram (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      we,
	input  wire logic [pkcs1uv_pkg::DIG_AW-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic [pkcs1uv_pkg::DIG_AW-1:0] raddr,
	output logic      [7:0]                rdata
);
	import pkcs1uv_pkg::*;

	logic [7:0] mem [MAX_DIGEST_BYTES];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, new data wins on an address collision
	always_ff @(posedge clk) begin
		if (we && waddr == raddr) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(we && waddr == raddr) |=> (rdata == $past(wdata)))
		else $error("digest ram: collision read lost the new write data");

endmodule
`default_nettype wire

@@ rtl/pkcs1uv_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkcs1uv_ctrl
// Per-byte phase machine: header, padding scan, body. Latches the first error,
// compares body bytes against the prefetched digest entry, issues results.
// ----------------------------------------------------------------------------
module pkcs1uv_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             blk_acc,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             last,
	input  wire logic                             mode,
	input  wire logic [pkcs1uv_pkg::LEN_W-1:0]    digest_len,
	input  wire logic [7:0]                       dig_rdata,
	output logic      [pkcs1uv_pkg::DIG_AW-1:0]   dig_raddr,
	output logic                                  res_valid,
	output pkcs1uv_pkg::res_t                     res
);
	import pkcs1uv_pkg::*;

	phase_t           phase_q, phase_n;
	logic [POS_W-1:0] pos_q, pos_n;
	status_t          err_q, err_n;
	logic [CUR_W-1:0] cur_q, cur_n;
	logic             sig;
	logic             msg;
	status_t          status;

	function automatic status_t latch_err(status_t cur, status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	assign sig = (mode == MODE_SIG);

	// Next state and result
	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		err_n   = err_q;
		cur_n   = cur_q;
		msg     = 1'b0;
		status  = ST_OK;
		if (blk_acc) begin
			unique case (phase_q)
				PH_HDR0: begin
					if (data_byte != HDR_LEAD) err_n = latch_err(err_n, ST_BAD_HEADER);
					phase_n = PH_HDR1;
				end
				PH_HDR1: begin
					if (data_byte != (sig ? TYPE_SIG : TYPE_ENC))
						err_n = latch_err(err_n, ST_BAD_HEADER);
					phase_n = PH_PAD;
				end
				PH_PAD: begin
					if (data_byte == SEP_BYTE) begin
						if (pos_q < POS_W'(MIN_SEP_INDEX))
							err_n = latch_err(err_n, ST_SHORT_PAD);
						phase_n = PH_BODY;
					end else if (sig && data_byte != PAD_SIG) begin
						err_n   = latch_err(err_n, ST_BAD_PAD);
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					if (sig) begin
						if (cur_q < digest_len && cur_q < CUR_W'(MAX_DIGEST_BYTES) &&
								data_byte != dig_rdata)
							err_n = latch_err(err_n, ST_DIGEST_MISMATCH);
						if (cur_q != {CUR_W{1'b1}}) cur_n = cur_q + 1'b1;
					end else if (err_q == ST_OK) begin
						msg = 1'b1;
					end
				end
			endcase

			if (pos_q != POS_W'(MAX_BLOCK_BYTES - 1)) pos_n = pos_q + 1'b1;

			// End of block: final checks, then back to the header
			if (last) begin
				if (phase_n == PH_HDR1) begin
					err_n = latch_err(err_n, ST_BAD_HEADER);
				end else if (phase_n == PH_PAD) begin
					err_n = latch_err(err_n, ST_NO_SEP);
				end else if (sig && (err_n == ST_OK || err_n == ST_DIGEST_MISMATCH) &&
						(digest_len > LEN_W'(MAX_DIGEST_BYTES) || cur_n != digest_len)) begin
					err_n = ST_LEN_MISMATCH;
				end
				status  = err_n;
				phase_n = PH_HDR0;
				pos_n   = '0;
				err_n   = ST_OK;
				cur_n   = '0;
			end
		end
	end

	// Result item
	always_comb begin
		res_valid     = blk_acc && (msg || last);
		res.msg_byte  = msg ? data_byte : 8'h00;
		res.msg_valid = msg;
		res.done_res  = blk_acc && last;
		res.status    = status;
	end

	// Prefetch the entry for the cursor value of the next byte
	assign dig_raddr = cur_n[DIG_AW-1:0];

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			pos_q   <= '0;
			err_q   <= ST_OK;
			cur_q   <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			err_q   <= err_n;
			cur_q   <= cur_n;
		end
	end

	a_last_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_acc && last) |=> (phase_q == PH_HDR0 && pos_q == '0 && cur_q == '0 &&
			err_q == ST_OK))
		else $error("ctrl: block end did not rearm the header phase");

	a_msg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.msg_valid) |-> (!sig && err_q == ST_OK && phase_q == PH_BODY))
		else $error("ctrl: message byte passed outside a clean encryption body");

	a_cur_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!blk_acc |=> $stable(cur_q))
		else $error("ctrl: digest cursor moved without a block byte");

endmodule
`default_nettype wire

@@ rtl/pkcs1uv_unpad_verify.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkcs1_v15_unpad_verify
// PKCS#1 v1.5 block type 2 unpad and block type 1 signature check on a byte
// stream, with a loadable expected-digest store.
// ----------------------------------------------------------------------------
// Results are registered: a result appears on m_* in the cycle after its input transfer.
// Throughput: one byte per cycle while the output is not stalled; the digest entry
//   for the next body byte is prefetched from the store, so no byte waits on a memory read.
// Reset clears the phase, position, error and cursor state and the config
//   registers (mode 0, digest_len 32); digest bytes must be loaded before use.
// ----------------------------------------------------------------------------
module pkcs1_v15_unpad_verify (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_addr,
	input  wire logic [pkcs1uv_pkg::LEN_W-1:0] cfg_wdata,
	// Input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,  // [7:0] data_byte, [13:8] digest_index
	input  wire logic                          s_tuser,  // [0] action
	input  wire logic                          s_tlast,
	// Result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [15:0]                   m_tdata,  // [7:0] msg_byte, [10:8] status
	output logic                               m_tuser,  // [0] msg_valid
	output logic                               m_tlast   // done_res
);
	import pkcs1uv_pkg::*;

	logic             mode_q;
	logic [LEN_W-1:0] digest_len_q;
	logic             s_acc;
	logic             blk_acc;
	logic             dig_we;
	logic [7:0]       data_byte;
	logic [5:0]       digest_index;
	logic [DIG_AW-1:0] dig_raddr;
	logic [7:0]       dig_rdata;
	logic             res_valid;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	assign data_byte    = s_tdata[7:0];
	assign digest_index = s_tdata[13:8];

	// Input transfer; an output register decouples the two sides
	assign s_tready = !out_valid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign blk_acc  = s_acc && (s_tuser == ACT_BLOCK);
	assign dig_we   = s_acc && (s_tuser == ACT_DIGEST) &&
		(32'(digest_index) < MAX_DIGEST_BYTES);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENC;
			digest_len_q <= DIGEST_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MODE:       mode_q       <= cfg_wdata[0];
				CFG_DIGEST_LEN: digest_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pkcs1uv_digest_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (dig_we),
		.waddr  (digest_index[DIG_AW-1:0]),
		.wdata  (data_byte),
		.raddr  (dig_raddr),
		.rdata  (dig_rdata)
	);

	pkcs1uv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_acc    (blk_acc),
		.data_byte  (data_byte),
		.last       (s_tlast),
		.mode       (mode_q),
		.digest_len (digest_len_q),
		.dig_rdata  (dig_rdata),
		.dig_raddr  (dig_raddr),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_acc && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.status, out_q.msg_byte};
	assign m_tuser  = out_q.msg_valid;
	assign m_tlast  = out_q.done_res;

endmodule
`default_nettype wire

@@ tb/sv/pkcs1uv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs1uv_checker
// Scoreboard for pkcs1_v15_unpad_verify. Follows the register writes, runs its
// own copy of the padding phase machine on every input transfer, and checks
// each result transfer field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module pkcs1uv_checker
	import pkcs1uv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [15:0]      s_tdata,  // [7:0] data_byte, [13:8] digest_index
	input  logic             s_tuser,  // [0] action
	input  logic             s_tlast,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [15:0]      m_tdata,  // [7:0] msg_byte, [10:8] status
	input  logic             m_tuser,  // [0] msg_valid
	input  logic             m_tlast,
	input  logic             run_done,
	output int               fail_count,
	output int               outstanding
);

	// Mirrored registers
	logic             mode_q;
	logic [LEN_W-1:0] dlen_q;

	// Phase machine copy
	phase_t           ph;
	logic [9:0]       pos;
	status_t          err;
	logic [CUR_W-1:0] cur;
	logic [7:0]       dstore [0:MAX_DIGEST_BYTES-1];

	res_t             due [$];
	bit               swept;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		swept       = 1'b0;
	end

	task automatic flag(input string msg);
		fail_count++;
		$display("[%0t] checker: %s", $time, msg);
	endtask

	task automatic latch_err(input status_t code);
		if (err == ST_OK)
			err = code;
	endtask

	// Advance the phase machine by one input transfer; queue the result it causes
	task automatic track_block_byte(input logic act, input logic [7:0] b,
			input logic [5:0] di, input logic lst);
		res_t r;
		logic sig;
		logic mv;
		sig = mode_q;
		mv  = 1'b0;
		if (act == ACT_DIGEST) begin
			dstore[di] = b;
			return;
		end
		case (ph)
			PH_HDR0: begin
				if (b != HDR_LEAD)
					latch_err(ST_BAD_HEADER);
				ph = PH_HDR1;
			end
			PH_HDR1: begin
				if (b != (sig ? TYPE_SIG : TYPE_ENC))
					latch_err(ST_BAD_HEADER);
				ph = PH_PAD;
			end
			PH_PAD: begin
				if (b == SEP_BYTE) begin
					if (pos < MIN_SEP_INDEX)
						latch_err(ST_SHORT_PAD);
					ph = PH_BODY;
				end else if (sig && b != PAD_SIG) begin
					latch_err(ST_BAD_PAD);
					ph = PH_BODY;
				end
			end
			default: begin
				if (sig) begin
					if (cur < dlen_q && cur < MAX_DIGEST_BYTES && b != dstore[cur[5:0]])
						latch_err(ST_DIGEST_MISMATCH);
					if (cur < 7'd127)
						cur++;
				end else if (err == ST_OK) begin
					mv = 1'b1;
				end
			end
		endcase
		if (pos < MAX_BLOCK_BYTES - 1)
			pos++;
		r.status = ST_OK;
		if (lst) begin
			// closing checks; a length error outranks a digest error
			if (ph == PH_HDR1)
				latch_err(ST_BAD_HEADER);
			else if (ph == PH_PAD)
				latch_err(ST_NO_SEP);
			else if (sig && (err == ST_OK || err == ST_DIGEST_MISMATCH) &&
					(dlen_q > MAX_DIGEST_BYTES || cur != dlen_q))
				err = ST_LEN_MISMATCH;
			r.status = err;
			ph  = PH_HDR0;
			pos = '0;
			err = ST_OK;
			cur = '0;
		end
		if (mv || lst) begin
			r.msg_byte  = mv ? b : 8'h00;
			r.msg_valid = mv;
			r.done_res  = lst;
			due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			mode_q = MODE_ENC;
			dlen_q = DIGEST_LEN_RST;
			ph     = PH_HDR0;
			pos    = '0;
			err    = ST_OK;
			cur    = '0;
			due.delete();
		end else begin
			// result transfer against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (due.size() == 0) begin
					flag($sformatf("unexpected result tdata=%04h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = due.pop_front();
					if (m_tdata[7:0] !== want.msg_byte)
						flag($sformatf("msg_byte %02h, want %02h", m_tdata[7:0], want.msg_byte));
					if (m_tuser !== want.msg_valid)
						flag($sformatf("msg_valid %b, want %b", m_tuser, want.msg_valid));
					if (m_tlast !== want.done_res)
						flag($sformatf("done_res %b, want %b", m_tlast, want.done_res));
					if (m_tdata[10:8] !== want.status)
						flag($sformatf("status %0d, want %0d", m_tdata[10:8], want.status));
				end
			end
			// input transfer
			if (s_tvalid && s_tready)
				track_block_byte(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tlast);
			// register writes land at this edge
			if (cfg_we) begin
				if (cfg_addr == CFG_MODE)
					mode_q = cfg_wdata[0];
				else
					dlen_q = cfg_wdata;
			end
			if (run_done && !swept) begin
				swept = 1'b1;
				while (due.size() != 0) begin
					want = due.pop_front();
					flag($sformatf("result never arrived: msg %02h valid %b done %b status %0d",
						want.msg_byte, want.msg_valid, want.done_res, want.status));
				end
			end
		end
		outstanding = due.size();
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for pkcs1_v15_unpad_verify: short directed blocks, then random
// type 1 and type 2 blocks over several register settings, with flawed blocks,
// digest reloads and noise mixed in. Checking is done by pkcs1uv_checker.
// ----------------------------------------------------------------------------
module testbench;
	import pkcs1uv_pkg::*;

	localparam int TARGET_ITEMS = 1950;
	localparam int QUIET_ITEMS  = 200;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_addr;
	logic [LEN_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;  // [7:0] data_byte, [13:8] digest_index
	logic             s_tuser;  // [0] action
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [15:0]      m_tdata;  // [7:0] msg_byte, [10:8] status
	logic             m_tuser;  // [0] msg_valid
	logic             m_tlast;
	logic             run_done;
	int               fails;
	int               outstanding;

	// Stimulus-side view of what has been loaded and configured
	logic [7:0]       digest_img [0:MAX_DIGEST_BYTES-1];
	logic [7:0]       blk [$];
	logic             cur_mode;
	logic [LEN_W-1:0] cur_len;
	int               items_sent;
	bit               quiet;

	pkcs1_v15_unpad_verify dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	pkcs1uv_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.run_done    (run_done),
		.fail_count  (fails),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held       = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && !quiet && items_sent >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (quiet) begin
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 16);
			end
		end
	end

	// One input transfer; entered and left on a falling edge
	task automatic send_item(input logic act, input logic [7:0] b, input logic [5:0] di,
			input logic lst);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, di, b};
		s_tuser  <= act;
		s_tlast  <= lst;
		do @(posedge clk); while (s_tready !== 1'b1);
		items_sent++;
		quiet = (items_sent >= TARGET_ITEMS - QUIET_ITEMS);
		@(negedge clk);
	endtask

	task automatic send_block();
		for (int i = 0; i < blk.size(); i++)
			send_item(ACT_BLOCK, blk[i], 6'($urandom_range(0, 63)), i == blk.size() - 1);
	endtask

	task automatic load_digest(input logic [5:0] di, input logic [7:0] b);
		digest_img[di] = b;
		send_item(ACT_DIGEST, b, di, 1'($urandom_range(0, 1)));
	endtask

	// Stop offering and wait until every expected result has been taken
	task automatic settle();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic md, input logic [LEN_W-1:0] len);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_MODE;
		cfg_wdata <= LEN_W'(md);
		@(negedge clk);
		cfg_addr  <= CFG_DIGEST_LEN;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_mode = md;
		cur_len  = len;
	endtask

	// Build one encoded block for mode md; body_n >= 0 forces the body length.
	// Flaws: 1 lead byte, 2 type byte, 3 short padding, 4 stray pad byte,
	// 5 digest length off by one, 6 wrong digest byte, 7 cut short.
	task automatic make_block(input logic md, input int body_n);
		int flaw, padn, dn, lim, k, n;
		logic [7:0] b;
		blk.delete();
		flaw = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 7);
		padn = (flaw == 3) ? $urandom_range(0, 7) : $urandom_range(8, 24);
		blk.push_back((flaw == 1) ? 8'($urandom_range(1, 255)) : HDR_LEAD);
		if (flaw == 2) begin
			b = $urandom_range(0, 1) ? (md ? TYPE_ENC : TYPE_SIG) : 8'($urandom_range(0, 255));
			if (b == (md ? TYPE_SIG : TYPE_ENC))
				b ^= 8'h40;
		end else begin
			b = md ? TYPE_SIG : TYPE_ENC;
		end
		blk.push_back(b);
		repeat (padn)
			blk.push_back(md ? PAD_SIG : 8'($urandom_range(1, 255)));
		if (md && flaw == 4 && padn > 0)
			blk[2 + $urandom_range(0, padn - 1)] = 8'($urandom_range(1, 254));
		blk.push_back(SEP_BYTE);
		if (md) begin
			if (body_n >= 0)
				dn = body_n;
			else if (cur_len > MAX_DIGEST_BYTES)
				dn = $urandom_range(0, 80);
			else
				dn = cur_len;
			if (flaw == 5)
				dn = (dn == 0 || $urandom_range(0, 1)) ? dn + 1 : dn - 1;
			for (k = 0; k < dn; k++)
				blk.push_back((k < MAX_DIGEST_BYTES) ? digest_img[k] : 8'($urandom_range(0, 255)));
			lim = dn;
			if (cur_len < lim)
				lim = cur_len;
			if (MAX_DIGEST_BYTES < lim)
				lim = MAX_DIGEST_BYTES;
			if (flaw == 6 && lim > 0) begin
				k = $urandom_range(0, lim - 1);
				blk[3 + padn + k] ^= 8'($urandom_range(1, 255));
			end
		end else begin
			dn = (body_n >= 0) ? body_n : $urandom_range(0, 24);
			repeat (dn)
				blk.push_back(8'($urandom_range(0, 255)));
		end
		// unfinished block: ends in the header, the padding or the body
		if (flaw == 7) begin
			n = $urandom_range(1, blk.size() - 1);
			while (blk.size() > n)
				void'(blk.pop_back());
		end
	endtask

	task automatic start_phase(input int phase_no);
		case (phase_no)
			0: set_config(MODE_ENC, 7'd32);
			1: set_config(MODE_SIG, 7'd32);
			2: set_config(MODE_SIG, 7'd1);
			3: set_config(MODE_SIG, 7'd64);
			4: set_config(MODE_SIG, 7'd0);
			5: set_config(MODE_SIG, 7'd127);
			6: set_config(MODE_ENC, 7'd1);
			default: set_config(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0) ?
				7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64)));
		endcase
	endtask

	initial begin
		int phase_no, phase_start, blocks, sel, body_n;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_addr   = CFG_MODE;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = ACT_BLOCK;
		s_tlast    = 1'b0;
		run_done   = 1'b0;
		items_sent = 0;
		quiet      = 1'b0;
		cur_mode   = MODE_ENC;
		cur_len    = DIGEST_LEN_RST;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the whole digest store first, with both byte extremes at both ends
		for (int i = 0; i < MAX_DIGEST_BYTES; i++)
			load_digest(6'(i), (i == 0) ? 8'h00 : (i == MAX_DIGEST_BYTES - 1) ? 8'hFF :
				8'($urandom_range(0, 255)));

		// Directed: one-byte blocks, a block ending after a good type byte,
		// and a separator on the last byte (empty message)
		blk = '{8'h00};
		send_block();
		blk = '{8'hFF};
		send_block();
		blk = '{HDR_LEAD, TYPE_ENC};
		send_block();
		blk = '{HDR_LEAD, TYPE_ENC, 8'h01, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFF, 8'h55, 8'hAA,
			SEP_BYTE};
		send_block();
		// Mode switched between the lead byte and the type byte of one block
		send_item(ACT_BLOCK, HDR_LEAD, 6'h3F, 1'b0);
		settle();
		set_config(MODE_SIG, 7'd4);
		blk = '{TYPE_SIG, PAD_SIG, PAD_SIG, PAD_SIG, PAD_SIG, PAD_SIG, PAD_SIG, PAD_SIG,
			PAD_SIG, SEP_BYTE, digest_img[0], digest_img[1], digest_img[2], digest_img[3]};
		send_block();
		settle();

		// Random phases over several register settings
		phase_no = 0;
		while (items_sent < TARGET_ITEMS) begin
			start_phase(phase_no);
			phase_start = items_sent;
			blocks      = 0;
			while (items_sent - phase_start < PHASE_ITEMS && items_sent < TARGET_ITEMS) begin
				sel = $urandom_range(0, 19);
				if (sel < 2) begin
					load_digest(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
				end else if (sel < 4) begin
					// noise block
					blk.delete();
					repeat ($urandom_range(1, 12))
						blk.push_back(8'($urandom_range(0, 255)));
					send_block();
				end else if (sel < 5) begin
					// block built for the other mode
					make_block(~cur_mode, -1);
					send_block();
				end else begin
					body_n = -1;
					if (blocks == 3 && (phase_no == 0 || phase_no == 5))
						body_n = cur_mode ? 140 : 600;
					make_block(cur_mode, body_n);
					send_block();
					blocks++;
				end
			end
			settle();
			phase_no++;
		end

		run_done <= 1'b1;
		repeat (3) @(negedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ pkcs1_v15_unpad_verify.f @@
rtl/pkcs1uv_pkg.sv
rtl/pkcs1uv_digest_ram.sv
rtl/pkcs1uv_ctrl.sv
rtl/pkcs1uv_unpad_verify.sv
tb/sv/pkcs1uv_checker.sv
tb/sv/testbench.sv
